// ----- sv/tice_pkg.sv -----
// shared constants and controller/datapath interface types for the trie count engine
package tice_pkg;

    localparam int NODE_COUNT = 16384;
    localparam int ALPHABET   = 26;
    localparam int NODE_W     = $clog2(NODE_COUNT);
    localparam int LETTER_W   = 5;
    localparam int COUNT_W    = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic               ACT_INSERT = 1'b0;
    localparam logic               ACT_QUERY  = 1'b1;

    typedef logic [ALPHABET-1:0][NODE_W-1:0] row_t;

    typedef struct packed {
        logic clr_wr;
        logic capture;
        logic row_rd;
        logic step;
        logic res_zero;
        logic cnt_rd;
        logic cnt_upd;
        logic load_out;
    } tice_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic step_ok;
        logic stop;
        logic last_reg;
        logic out_free;
    } tice_sts_t;

endpackage

// ----- sv/tice_ctrl.sv -----
// control state machine for the trie count engine
module tice_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                last,
    output logic                in_ready,
    input  tice_pkg::tice_sts_t sts,
    output tice_pkg::tice_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW,
        S_CNT_ADDR,
        S_CNT,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (sts.step_ok)
                    begin
                        cmd.row_rd = 1'b1;
                        state_next = S_ROW;
                    end
                    else if (last)
                    begin
                        state_next = S_CNT_ADDR;
                    end
                end
            end
            S_ROW:
            begin
                cmd.step   = 1'b1;
                state_next = sts.last_reg ? S_CNT_ADDR : S_IDLE;
            end
            S_CNT_ADDR:
            begin
                if (sts.stop)
                begin
                    cmd.res_zero = 1'b1;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.cnt_rd = 1'b1;
                    state_next = S_CNT;
                end
            end
            S_CNT:
            begin
                cmd.cnt_upd = 1'b1;
                state_next  = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/tice_dp.sv -----
// datapath of the trie count engine: node store, count store, walk state, result register
module tice_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  action,
    input  logic [tice_pkg::LETTER_W-1:0]         letter,
    input  logic                                  last,
    input  tice_pkg::tice_cmd_t                   cmd,
    output tice_pkg::tice_sts_t                   sts,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [tice_pkg::COUNT_W-1:0]          count,
    output logic                                  store_full
);

    // node store: one row of child pointers per node
    tice_pkg::row_t row_mem [tice_pkg::NODE_COUNT];
    logic [tice_pkg::COUNT_W-1:0] cnt_mem [tice_pkg::NODE_COUNT];

    logic                          action_reg;
    logic [tice_pkg::LETTER_W-1:0] letter_reg;
    logic                          last_reg;

    logic [tice_pkg::NODE_W-1:0]   current_node_reg;
    logic [tice_pkg::NODE_W-1:0]   nodes_used_reg;
    logic                          miss_reg;
    logic                          full_reg;
    logic [tice_pkg::NODE_W-1:0]   clr_cnt_reg;

    tice_pkg::row_t                row_q;
    logic [tice_pkg::COUNT_W-1:0]  cnt_q;
    logic [tice_pkg::COUNT_W-1:0]  result_reg;

    logic                          out_valid_reg;
    logic [tice_pkg::COUNT_W-1:0]  count_reg;
    logic                          store_full_reg;

    logic [tice_pkg::NODE_W-1:0]   child;
    logic                          child_none;
    logic                          can_alloc;
    logic                          alloc;
    logic [tice_pkg::NODE_W-1:0]   new_node;
    tice_pkg::row_t                row_wdata;
    logic                          row_we;
    logic [tice_pkg::NODE_W-1:0]   wr_addr;
    logic [tice_pkg::COUNT_W-1:0]  cnt_inc;
    logic                          cnt_we;
    logic [tice_pkg::COUNT_W-1:0]  cnt_wdata;

    assign child      = row_q[letter_reg];
    assign child_none = (child == '0);
    assign can_alloc  = (nodes_used_reg != tice_pkg::NODE_W'(tice_pkg::NODE_COUNT - 1));
    assign new_node   = nodes_used_reg + tice_pkg::NODE_W'(1);
    assign alloc      = cmd.step && child_none && (action_reg == tice_pkg::ACT_INSERT)
                        && can_alloc;

    always_comb
    begin
        row_wdata = row_q;
        row_wdata[letter_reg] = new_node;
        if (cmd.clr_wr)
        begin
            row_wdata = '0;
        end
    end

    assign row_we  = cmd.clr_wr || alloc;
    assign wr_addr = cmd.clr_wr ? clr_cnt_reg : current_node_reg;

    // saturating increment
    assign cnt_inc   = (cnt_q == tice_pkg::COUNT_MAX) ? cnt_q
                                                      : cnt_q + tice_pkg::COUNT_W'(1);
    assign cnt_we    = cmd.clr_wr || (cmd.cnt_upd && (action_reg == tice_pkg::ACT_INSERT));
    assign cnt_wdata = cmd.clr_wr ? '0 : cnt_inc;

    assign sts.clr_last = (clr_cnt_reg == tice_pkg::NODE_W'(tice_pkg::NODE_COUNT - 1));
    assign sts.step_ok  = (letter < tice_pkg::LETTER_W'(tice_pkg::ALPHABET))
                          && !miss_reg && !full_reg;
    assign sts.stop     = miss_reg || full_reg;
    assign sts.last_reg = last_reg;
    assign sts.out_free = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign count      = count_reg;
    assign store_full = store_full_reg;

    // memories
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[wr_addr] <= row_wdata;
        end
        if (cmd.row_rd)
        begin
            row_q <= row_mem[current_node_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[wr_addr] <= cnt_wdata;
        end
        if (cmd.cnt_rd)
        begin
            cnt_q <= cnt_mem[current_node_reg];
        end
    end

    // request payload and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action;
            letter_reg <= letter;
            last_reg   <= last;
        end
        if (cmd.res_zero)
        begin
            result_reg <= '0;
        end
        else if (cmd.cnt_upd)
        begin
            result_reg <= (action_reg == tice_pkg::ACT_INSERT) ? cnt_inc : cnt_q;
        end
        if (cmd.load_out)
        begin
            count_reg      <= result_reg;
            store_full_reg <= (action_reg == tice_pkg::ACT_INSERT) && full_reg;
        end
    end

    // walk state, clear counter and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_node_reg <= '0;
            nodes_used_reg   <= '0;
            miss_reg         <= 1'b0;
            full_reg         <= 1'b0;
            clr_cnt_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr)
            begin
                clr_cnt_reg <= clr_cnt_reg + tice_pkg::NODE_W'(1);
            end
            if (cmd.step)
            begin
                if (!child_none)
                begin
                    current_node_reg <= child;
                end
                else if (action_reg == tice_pkg::ACT_INSERT)
                begin
                    if (can_alloc)
                    begin
                        nodes_used_reg   <= new_node;
                        current_node_reg <= new_node;
                    end
                    else
                    begin
                        full_reg <= 1'b1;
                    end
                end
                else
                begin
                    miss_reg <= 1'b1;
                end
            end
            if (cmd.load_out)
            begin
                current_node_reg <= '0;
                miss_reg         <= 1'b0;
                full_reg         <= 1'b0;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    a_alloc_bumps_used: assert property (@(posedge clk) disable iff (!rst_n)
        alloc |=> (nodes_used_reg == $past(nodes_used_reg) + tice_pkg::NODE_W'(1))
                  && (current_node_reg == nodes_used_reg))
        else $error("node allocation did not advance the node count");

    a_walk_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (current_node_reg == '0) && !miss_reg && !full_reg && out_valid_reg)
        else $error("walk not back at root after result");

    a_full_means_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && store_full_reg) |-> (count_reg == '0))
        else $error("dropped insert carries a nonzero count");

    a_no_step_when_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.row_rd |-> !miss_reg && !full_reg)
        else $error("lookup started after the walk stopped");

endmodule

// ----- sv/trie_insert_count_engine.sv -----
// top level of the trie string count engine
//
// Counts lower-case strings in a trie kept in a node store of NODE_COUNT nodes.
// A string arrives as one request per letter (action 0 insert, 1 query, letter
// a=0..z=25, last on the final letter). Each letter in range walks from the
// current node to its child; an insert allocates a new node when the child is
// absent, a query that meets an absent child marks a miss. The last letter
// produces exactly one result: an insert gives the string's count after the
// increment (saturating at 65535), a query gives the stored count or 0 when the
// string is absent. When the store has no free node an insert is dropped and
// reported with count 0 and store_full 1. Letters of 26 and above are skipped,
// but their last marker still ends the string. After reset the block clears
// both stores, one node row per cycle, over all NODE_COUNT (16384) nodes with
// in_ready low. A non-final letter then goes through the registered read of the
// node row followed by the child update, or is only captured when it is skipped
// or the walk has already stopped; a final letter goes through row read, child
// update, count read, count update and result load, with no row read or child
// update when it is skipped and no count read when the walk has stopped, and
// the result load waits for the output register to drain. One finished result
// may sit in the output register while the next string's letters are taken.
module trie_insert_count_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [tice_pkg::LETTER_W-1:0] letter,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tice_pkg::COUNT_W-1:0]  count,
    output logic                          store_full
);

    // commands from the controller, status back from the datapath
    tice_pkg::tice_cmd_t cmd;
    tice_pkg::tice_sts_t sts;

    tice_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .last     (last),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tice_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .action     (action),
        .letter     (letter),
        .last       (last),
        .cmd        (cmd),
        .sts        (sts),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .count      (count),
        .store_full (store_full)
    );

endmodule

// ----- bench/tb_trie_insert_count_engine.sv -----
// self-checking bench for the trie string count engine: directed table, random words
`timescale 1ns / 1ps

module tb_trie_insert_count_engine;

    // letters used by the directed table
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_A       = 5'd0;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_B       = 5'd1;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_C       = 5'd2;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_K       = 5'd10;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_L       = 5'd11;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_M       = 5'd12;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_Q       = 5'd16;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_Z       = 5'd25;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_SKIP_LO = 5'd26;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_SKIP_HI = 5'd30;
    localparam logic [tice_pkg::LETTER_W-1:0] LTR_TOP     = {tice_pkg::LETTER_W{1'b1}};

    // the clearing pass alone keeps the block silent while it clears all NODE_COUNT nodes
    localparam int QUIET_LIMIT   = 100000;
    localparam int RANDOM_ITEMS  = 1400;

    typedef struct packed {
        logic [tice_pkg::COUNT_W-1:0] cnt;
        logic                         full;
    } word_result_t;

    typedef struct packed {
        logic                          act;
        logic [tice_pkg::LETTER_W-1:0] ltr;
        logic                          lst;
        logic                          typed;
        logic [tice_pkg::COUNT_W-1:0]  cnt;
        logic                          full;
    } probe_row_t;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_t;

    // directed rows; a typed result is used as is, otherwise the trie predictor decides
    localparam probe_row_t PROBES [23] = '{
        '{tice_pkg::ACT_QUERY, LTR_A, 1'b1, 1'b1, 16'd0, 1'b0},  // empty trie after reset
        '{tice_pkg::ACT_INSERT, LTR_A, 1'b1, 1'b1, 16'd1, 1'b0},
        '{tice_pkg::ACT_INSERT, LTR_A, 1'b1, 1'b1, 16'd2, 1'b0},
        '{tice_pkg::ACT_QUERY, LTR_A, 1'b1, 1'b1, 16'd2, 1'b0},
        '{tice_pkg::ACT_INSERT, LTR_Z, 1'b1, 1'b1, 16'd1, 1'b0},  // top letter
        '{tice_pkg::ACT_INSERT, LTR_A, 1'b0, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_INSERT, LTR_B, 1'b1, 1'b1, 16'd1, 1'b0},
        '{tice_pkg::ACT_QUERY, LTR_A, 1'b0, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_QUERY, LTR_C, 1'b1, 1'b1, 16'd0, 1'b0},  // miss on the last letter
        '{tice_pkg::ACT_QUERY, LTR_Q, 1'b0, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_QUERY, LTR_A, 1'b1, 1'b1, 16'd0, 1'b0},  // miss stops the walk
        '{tice_pkg::ACT_INSERT, LTR_TOP, 1'b1, 1'b0, 16'd0, 1'b0},  // skipped letter ends on root
        '{tice_pkg::ACT_INSERT, LTR_A, 1'b0, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_INSERT, LTR_SKIP_LO, 1'b0, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_INSERT, LTR_B, 1'b1, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_QUERY, LTR_SKIP_HI, 1'b1, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_QUERY, LTR_M, 1'b0, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_INSERT, LTR_A, 1'b1, 1'b1, 16'd0, 1'b0},  // insert after a miss is dropped
        '{tice_pkg::ACT_INSERT, LTR_K, 1'b0, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_QUERY, LTR_L, 1'b1, 1'b1, 16'd0, 1'b0},  // mixed, query misses
        '{tice_pkg::ACT_INSERT, LTR_K, 1'b0, 1'b0, 16'd0, 1'b0},
        '{tice_pkg::ACT_QUERY, LTR_TOP, 1'b1, 1'b0, 16'd0, 1'b0},  // prefix only, count stays 0
        '{tice_pkg::ACT_QUERY, LTR_Z, 1'b1, 1'b1, 16'd1, 1'b0}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          action;
    logic [tice_pkg::LETTER_W-1:0] letter;
    logic                          last;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [tice_pkg::COUNT_W-1:0]  count;
    logic                          store_full;

    // typed result riding along with the request on the input side
    logic                          row_typed;
    logic [tice_pkg::COUNT_W-1:0]  row_cnt;
    logic                          row_full;

    // predictor copy of the trie
    int unsigned                   child_of [int unsigned];
    bit [tice_pkg::COUNT_W-1:0]    word_count [tice_pkg::NODE_COUNT];
    int unsigned                   nodes_used = 0;
    int unsigned                   walk_node = 0;
    bit                            walk_missed = 1'b0;
    bit                            walk_full = 1'b0;

    word_result_t                  results_due [$];
    int                            mismatches = 0;
    int                            quiet_cycles;

    // sender burst shaping
    int                            burst_left;
    bit                            no_gaps;

    // receiver stall pattern
    rx_mode_t                      rx_mode = RX_OPEN;
    int                            rx_phase = 0;
    int                            rx_hold = 0;
    logic                          rx_level = 1'b0;

    trie_insert_count_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .letter     (letter),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .count      (count),
        .store_full (store_full)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        begin
            $display("%0t mismatch: %s", $time, msg);
            mismatches++;
        end
    endtask

    // one letter through the trie; returns the word result on a last letter
    task automatic trie_step(input logic act, input logic [tice_pkg::LETTER_W-1:0] ltr,
                             input logic lst, output bit emits, output word_result_t res);
        int unsigned slot;
        begin
            emits = 1'b0;
            res   = '0;
            // a miss or a full store freezes the walk until the word ends
            if (ltr < tice_pkg::ALPHABET && !walk_missed && !walk_full) begin
                slot = walk_node * tice_pkg::ALPHABET + ltr;
                if (child_of.exists(slot)) begin
                    walk_node = child_of[slot];
                end
                else if (act == tice_pkg::ACT_INSERT) begin
                    if (nodes_used + 1 < tice_pkg::NODE_COUNT) begin
                        nodes_used++;
                        child_of[slot] = nodes_used;
                        walk_node      = nodes_used;
                    end
                    else begin
                        walk_full = 1'b1;
                    end
                end
                else begin
                    walk_missed = 1'b1;
                end
            end
            if (lst) begin
                emits = 1'b1;
                // the action of the last letter picks the kind of result
                if (act == tice_pkg::ACT_INSERT) begin
                    if (walk_missed || walk_full) begin
                        res.full = walk_full;
                    end
                    else begin
                        if (word_count[walk_node] != tice_pkg::COUNT_MAX)
                            word_count[walk_node] = word_count[walk_node] + 1'b1;
                        res.cnt = word_count[walk_node];
                    end
                end
                else if (!walk_missed && !walk_full) begin
                    res.cnt = word_count[walk_node];
                end
                walk_node   = 0;
                walk_missed = 1'b0;
                walk_full   = 1'b0;
            end
        end
    endtask

    // request and result bookkeeping, all on the rising edge
    always @(posedge clk) begin
        bit           emits;
        word_result_t res;
        word_result_t want;
        if (rst_n && in_valid && in_ready) begin
            trie_step(action, letter, last, emits, res);
            if (emits) begin
                if (row_typed) begin
                    res.cnt  = row_cnt;
                    res.full = row_full;
                end
                results_due.push_back(res);
            end
        end
        if (rst_n && out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                flag_mismatch($sformatf("result count=%0d store_full=%0d with no word pending",
                                        count, store_full));
            end
            else begin
                want = results_due.pop_front();
                if (count !== want.cnt)
                    flag_mismatch($sformatf("count got %0d want %0d", count, want.cnt));
                if (store_full !== want.full)
                    flag_mismatch($sformatf("store_full got %0b want %0b",
                                            store_full, want.full));
            end
        end
    end

    // watchdog on cycles with no request and no result moving
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("trie_insert_count_engine test failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: switches between open, coin-flip, sparse and long-run stall modes
    always @(negedge clk) begin
        if (rx_phase == 0) begin
            rx_mode  = rx_mode_t'($urandom_range(0, 3));
            rx_phase = $urandom_range(50, 300);
        end
        rx_phase--;
        case (rx_mode)
            RX_OPEN:   out_ready <= 1'b1;
            RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
            default:
            begin
                if (rx_hold == 0) begin
                    rx_hold  = $urandom_range(1, 20);
                    rx_level = ~rx_level;
                end
                rx_hold--;
                out_ready <= rx_level;
            end
        endcase
    end

    // present one request at a falling edge and hold it until accepted
    task automatic send_letter(input logic act, input logic [tice_pkg::LETTER_W-1:0] ltr,
                               input logic lst, input logic typed,
                               input logic [tice_pkg::COUNT_W-1:0] tcnt, input logic tfull);
        int gap;
        begin
            gap = 0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if (!no_gaps)
                    gap = $urandom_range(1, 15);
            end
            burst_left--;
            @(negedge clk);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid  <= 1'b1;
            action    <= act;
            letter    <= ltr;
            last      <= lst;
            row_typed <= typed;
            row_cnt   <= tcnt;
            row_full  <= tfull;
            do @(posedge clk); while (!in_ready);
        end
    endtask

    // stop sending and wait until every pending word result is back
    task automatic settle();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            while (results_due.size() != 0) @(negedge clk);
        end
    endtask

    // short words over a small letter pool so words repeat; some noisy ones
    task automatic send_random_word(output int counted);
        int                            wlen;
        int                            pick;
        logic                          act;
        logic                          a;
        bit                            noisy;
        logic [tice_pkg::LETTER_W-1:0] ltr;
        begin
            counted = 0;
            wlen    = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
            act     = $urandom_range(0, 1) ? tice_pkg::ACT_QUERY : tice_pkg::ACT_INSERT;
            noisy   = ($urandom_range(0, 9) == 0);
            for (int i = 0; i < wlen; i++) begin
                pick = $urandom_range(0, 19);
                if (pick < 14)
                    ltr = tice_pkg::LETTER_W'($urandom_range(0, 3));
                else if (pick < 18)
                    ltr = tice_pkg::LETTER_W'($urandom_range(0, tice_pkg::ALPHABET - 1));
                else
                    ltr = tice_pkg::LETTER_W'($urandom_range(tice_pkg::ALPHABET, LTR_TOP));
                a = (noisy && $urandom_range(0, 1)) ? ~act : act;
                send_letter(a, ltr, i == wlen - 1, 1'b0, '0, 1'b0);
                counted++;
            end
        end
    endtask

    initial begin
        int sent;
        int n;
        int next_pause;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = tice_pkg::ACT_INSERT;
        letter       = '0;
        last         = 1'b0;
        row_typed    = 1'b0;
        row_cnt      = '0;
        row_full     = 1'b0;
        burst_left   = 0;
        no_gaps      = 1'b0;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed table; the first request waits out the clearing pass
        foreach (PROBES[i])
            send_letter(PROBES[i].act, PROBES[i].ltr, PROBES[i].lst,
                        PROBES[i].typed, PROBES[i].cnt, PROBES[i].full);
        settle();

        // random words, with a full drain every 100 to 300 requests
        sent       = 0;
        next_pause = $urandom_range(100, 300);
        while (sent < RANDOM_ITEMS) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            send_random_word(n);
            sent += n;
            if (sent >= next_pause) begin
                settle();
                next_pause = sent + $urandom_range(100, 300);
            end
        end

        settle();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("trie_insert_count_engine test passed");
        else
            $display("trie_insert_count_engine test failed");
        $finish;
    end

endmodule
